### hw/rtl/tcad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcad_pkg;

    localparam int DistW = 29;   // width of the distance result
    localparam int RemW  = 140;  // 256 * det^2 and all trial products fit here
    localparam int AccW  = 110;  // q * norm
    localparam int NormW = 80;   // c . c

    // Payload that walks down the square-root search
    typedef struct packed {
        logic [RemW-1:0]  rem;   // 256 * det^2 minus q^2 * norm so far
        logic [AccW-1:0]  bacc;  // q * norm so far
        logic [NormW-1:0] norm;
        logic [DistW-1:0] q;
        logic             par;
    } root_t;

endpackage

`default_nettype wire

### hw/rtl/tcad_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tcad_front
    import tcad_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic signed [19:0] p1x,
    input  wire logic signed [19:0] p1y,
    input  wire logic signed [19:0] p1z,
    input  wire logic signed [19:0] p2x,
    input  wire logic signed [19:0] p2y,
    input  wire logic signed [19:0] p2z,
    input  wire logic signed [23:0] v1x,
    input  wire logic signed [23:0] v1y,
    input  wire logic signed [23:0] v1z,
    input  wire logic signed [23:0] v2x,
    input  wire logic signed [23:0] v2y,
    input  wire logic signed [23:0] v2z,
    output logic                    out_valid,
    output root_t                   out_data
);

    logic [8:0] vld_reg;

    // stage 1: separation and cross-product partial products
    logic signed [24:0] s1_s_reg [3];
    logic signed [39:0] s1_m_reg [6];
    // stage 2: magnitudes and signs
    logic [24:0]        s2_sm_reg [3];
    logic [39:0]        s2_cm_reg [3];
    logic [2:0]         s2_neg_reg;
    logic               s2_par_reg;
    // stage 3: 25x20 and 20x20 partial products
    logic [44:0]        s3_sl_reg [3];
    logic [44:0]        s3_sh_reg [3];
    logic [39:0]        s3_ll_reg [3];
    logic [39:0]        s3_lh_reg [3];
    logic [39:0]        s3_hh_reg [3];
    logic [2:0]         s3_neg_reg;
    logic               s3_par_reg;
    // stage 4: signed dot terms and squares
    logic signed [65:0] s4_t_reg [3];
    logic [NormW-1:0]   s4_sq_reg [3];
    logic               s4_par_reg;
    // stage 5: det and norm
    logic signed [67:0] s5_det_reg;
    logic [NormW-1:0]   s5_n_reg;
    logic               s5_par_reg;
    // stage 6: |det|
    logic [65:0]        s6_dm_reg;
    logic [NormW-1:0]   s6_n_reg;
    logic               s6_par_reg;
    // stage 7: limb products of det^2
    logic [43:0]        s7_p00_reg, s7_p01_reg, s7_p02_reg;
    logic [43:0]        s7_p11_reg, s7_p12_reg, s7_p22_reg;
    logic [NormW-1:0]   s7_n_reg;
    logic               s7_par_reg;
    // stage 8: partial sums
    logic [67:0]        s8_x_reg, s8_z_reg;
    logic [45:0]        s8_y_reg;
    logic [NormW-1:0]   s8_n_reg;
    logic               s8_par_reg;
    // stage 9: 256 * det^2
    logic [RemW-1:0]    s9_r_reg;
    logic [NormW-1:0]   s9_n_reg;
    logic               s9_par_reg;

    logic [8:0]         vld_next;
    logic signed [40:0] c_w [3];
    logic [79:0]        sq_w [3];
    logic [64:0]        t_w [3];
    logic [65:0]        det_abs_w;

    assign vld_next = {vld_reg[7:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        c_w[0] = {s1_m_reg[0][39], s1_m_reg[0]} - {s1_m_reg[1][39], s1_m_reg[1]};
        c_w[1] = {s1_m_reg[2][39], s1_m_reg[2]} - {s1_m_reg[3][39], s1_m_reg[3]};
        c_w[2] = {s1_m_reg[4][39], s1_m_reg[4]} - {s1_m_reg[5][39], s1_m_reg[5]};
        for (int i = 0; i < 3; i++)
        begin
            t_w[i]  = {20'b0, s3_sl_reg[i]} + {s3_sh_reg[i], 20'b0};
            sq_w[i] = {40'b0, s3_ll_reg[i]} + {19'b0, s3_lh_reg[i], 21'b0}
                    + {s3_hh_reg[i], 40'b0};
        end
        det_abs_w = s5_det_reg[67] ? 66'(-s5_det_reg) : s5_det_reg[65:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_s_reg[0] <= {v1x[23], v1x} - {v2x[23], v2x};
            s1_s_reg[1] <= {v1y[23], v1y} - {v2y[23], v2y};
            s1_s_reg[2] <= {v1z[23], v1z} - {v2z[23], v2z};
            s1_m_reg[0] <= p1y * p2z;
            s1_m_reg[1] <= p1z * p2y;
            s1_m_reg[2] <= p1z * p2x;
            s1_m_reg[3] <= p1x * p2z;
            s1_m_reg[4] <= p1x * p2y;
            s1_m_reg[5] <= p1y * p2x;

            for (int i = 0; i < 3; i++)
            begin
                s2_sm_reg[i]  <= s1_s_reg[i][24] ? 25'(-s1_s_reg[i]) : s1_s_reg[i];
                s2_cm_reg[i]  <= c_w[i][40] ? 40'(-c_w[i]) : c_w[i][39:0];
                s2_neg_reg[i] <= s1_s_reg[i][24] ^ c_w[i][40];
            end
            s2_par_reg <= (c_w[0] == '0) && (c_w[1] == '0) && (c_w[2] == '0);

            for (int i = 0; i < 3; i++)
            begin
                s3_sl_reg[i] <= {20'b0, s2_sm_reg[i]} * {25'b0, s2_cm_reg[i][19:0]};
                s3_sh_reg[i] <= {20'b0, s2_sm_reg[i]} * {25'b0, s2_cm_reg[i][39:20]};
                s3_ll_reg[i] <= s2_cm_reg[i][19:0] * s2_cm_reg[i][19:0];
                s3_lh_reg[i] <= s2_cm_reg[i][19:0] * s2_cm_reg[i][39:20];
                s3_hh_reg[i] <= s2_cm_reg[i][39:20] * s2_cm_reg[i][39:20];
            end
            s3_neg_reg <= s2_neg_reg;
            s3_par_reg <= s2_par_reg;

            for (int i = 0; i < 3; i++)
            begin
                s4_t_reg[i]  <= s3_neg_reg[i] ? -$signed({1'b0, t_w[i]})
                                              : $signed({1'b0, t_w[i]});
                s4_sq_reg[i] <= sq_w[i];
            end
            s4_par_reg <= s3_par_reg;

            s5_det_reg <= {{2{s4_t_reg[0][65]}}, s4_t_reg[0]}
                        + {{2{s4_t_reg[1][65]}}, s4_t_reg[1]}
                        + {{2{s4_t_reg[2][65]}}, s4_t_reg[2]};
            s5_n_reg   <= s4_sq_reg[0] + s4_sq_reg[1] + s4_sq_reg[2];
            s5_par_reg <= s4_par_reg;

            s6_dm_reg  <= det_abs_w;
            s6_n_reg   <= s5_n_reg;
            s6_par_reg <= s5_par_reg;

            s7_p00_reg <= s6_dm_reg[21:0]  * s6_dm_reg[21:0];
            s7_p01_reg <= s6_dm_reg[21:0]  * s6_dm_reg[43:22];
            s7_p02_reg <= s6_dm_reg[21:0]  * s6_dm_reg[65:44];
            s7_p11_reg <= s6_dm_reg[43:22] * s6_dm_reg[43:22];
            s7_p12_reg <= s6_dm_reg[43:22] * s6_dm_reg[65:44];
            s7_p22_reg <= s6_dm_reg[65:44] * s6_dm_reg[65:44];
            s7_n_reg   <= s6_n_reg;
            s7_par_reg <= s6_par_reg;

            s8_x_reg   <= {24'b0, s7_p00_reg} + {1'b0, s7_p01_reg, 23'b0};
            s8_y_reg   <= {1'b0, s7_p02_reg, 1'b0} + {2'b0, s7_p11_reg};
            s8_z_reg   <= {23'b0, s7_p12_reg, 1'b0} + {2'b0, s7_p22_reg, 22'b0};
            s8_n_reg   <= s7_n_reg;
            s8_par_reg <= s7_par_reg;

            s9_r_reg   <= ({72'b0, s8_x_reg} + {50'b0, s8_y_reg, 44'b0}
                         + {4'b0, s8_z_reg, 66'b0}) << 8;
            s9_n_reg   <= s8_n_reg;
            s9_par_reg <= s8_par_reg;
        end
    end

    assign out_valid     = vld_reg[8];
    assign out_data.rem  = s9_r_reg;
    assign out_data.bacc = '0;
    assign out_data.norm = s9_n_reg;
    assign out_data.q    = '0;
    assign out_data.par  = s9_par_reg;

endmodule

`default_nettype wire

### hw/rtl/tcad_root_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module tcad_root_stage
    import tcad_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  root_t      in_data,
    output logic       out_valid,
    output root_t      out_data
);

    logic        vld_reg;
    root_t       data_reg;
    root_t       data_next;
    logic [RemW-1:0] trial_w;

    // (q + 2^b)^2 N - q^2 N = q N 2^(b+1) + N 2^(2b)
    always_comb
    begin
        trial_w   = ({(RemW - AccW)'(0), in_data.bacc} << (BIT + 1))
                  + ({(RemW - NormW)'(0), in_data.norm} << (2 * BIT));
        data_next = in_data;
        if (trial_w <= in_data.rem)
        begin
            data_next.rem    = in_data.rem - trial_w;
            data_next.bacc   = in_data.bacc + ({(AccW - NormW)'(0), in_data.norm} << BIT);
            data_next.q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

### hw/rtl/track_closest_approach_distance.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake                 | Payload
// --------+---------------------------+-------------------------------------------
// in      | in_valid / in_ready       | first_p*, second_p* (20b), first_v*, second_v* (24b)
// out     | out_valid / out_ready     | closest_distance (29b), parallel_flag
//
// One track pair is taken per cycle while the pipe is not held. From input
// transfer to output valid a pair passes 9 front stages (cross product, dot
// product, norm, det^2 in limbs), one stage per bit of the 29-bit square-root
// search, and the output register. The whole pipe advances on one enable: it
// holds only while the output register is full and not taken. Reset clears valid bits.
module track_closest_approach_distance
    import tcad_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [19:0] first_px,
    input  wire logic signed [19:0] first_py,
    input  wire logic signed [19:0] first_pz,
    input  wire logic signed [19:0] second_px,
    input  wire logic signed [19:0] second_py,
    input  wire logic signed [19:0] second_pz,
    input  wire logic signed [23:0] first_vx,
    input  wire logic signed [23:0] first_vy,
    input  wire logic signed [23:0] first_vz,
    input  wire logic signed [23:0] second_vx,
    input  wire logic signed [23:0] second_vy,
    input  wire logic signed [23:0] second_vz,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [DistW-1:0]        closest_distance,
    output logic                    parallel_flag
);

    logic             en;
    logic             vld_w  [DistW+1];
    root_t            data_w [DistW+1];
    logic             out_valid_reg;
    logic [DistW-1:0] dist_reg;
    logic             par_reg;

    // advance everything unless the result register is stuck
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    tcad_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .p1x       (first_px),
        .p1y       (first_py),
        .p1z       (first_pz),
        .p2x       (second_px),
        .p2y       (second_py),
        .p2z       (second_pz),
        .v1x       (first_vx),
        .v1y       (first_vy),
        .v1z       (first_vz),
        .v2x       (second_vx),
        .v2y       (second_vy),
        .v2z       (second_vz),
        .out_valid (vld_w[0]),
        .out_data  (data_w[0])
    );

    // decide the distance one bit per stage, most significant first
    for (genvar g = 0; g < DistW; g++)
    begin : g_root
        tcad_root_stage #(
            .BIT (DistW - 1 - g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vld_w[g]),
            .in_data   (data_w[g]),
            .out_valid (vld_w[g+1]),
            .out_data  (data_w[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_w[DistW];
        end
    end

    // drop the search result for parallel tracks: report zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= data_w[DistW].par ? '0 : data_w[DistW].q;
            par_reg  <= data_w[DistW].par;
        end
    end

    assign out_valid        = out_valid_reg;
    assign closest_distance = dist_reg;
    assign parallel_flag    = par_reg;

endmodule

`default_nettype wire

### tb/sv/tb_track_closest_approach_distance.sv
`timescale 1ns / 1ps

module tb_track_closest_approach_distance;
    import tcad_pkg::*;

    localparam int NumRandom = 1430;
    localparam int QuietTail = 150;     // last pending items go without idling
    localparam int StallLimit = 4000;   // cycles without any transfer
    localparam int DrainCycles = 60;    // a little over the pipe latency

    typedef struct {
        logic signed [19:0] p1x, p1y, p1z, p2x, p2y, p2z;
        logic signed [23:0] v1x, v1y, v1z, v2x, v2y, v2z;
    } track_pair_t;

    typedef struct {
        logic [DistW-1:0] dca;
        logic             par;
    } approach_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [19:0] first_px = '0, first_py = '0, first_pz = '0;
    logic signed [19:0] second_px = '0, second_py = '0, second_pz = '0;
    logic signed [23:0] first_vx = '0, first_vy = '0, first_vz = '0;
    logic signed [23:0] second_vx = '0, second_vy = '0, second_vz = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [DistW-1:0] closest_distance;
    logic parallel_flag;

    track_pair_t pair_queue[$];
    approach_t   approach_queue[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  in_took = 1'b0;
    int  in_gap = 0;
    int  out_gap = 0;
    bit  quiet = 1'b0;

    track_closest_approach_distance dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .first_px(first_px), .first_py(first_py), .first_pz(first_pz),
        .second_px(second_px), .second_py(second_py), .second_pz(second_pz),
        .first_vx(first_vx), .first_vy(first_vy), .first_vz(first_vz),
        .second_vx(second_vx), .second_vy(second_vy), .second_vz(second_vz),
        .out_valid(out_valid), .out_ready(out_ready),
        .closest_distance(closest_distance), .parallel_flag(parallel_flag)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Exact distance of closest approach: floor(16 |s.c| / |c|), saturated.
    function automatic approach_t closest_approach(track_pair_t t);
        logic signed [95:0] c0, c1, c2, s0, s1, s2, dot, nrm;
        logic [199:0] det, norm, rhs, lhs, trial;
        approach_t r;
        c0 = 96'(t.p1y) * 96'(t.p2z) - 96'(t.p1z) * 96'(t.p2y);
        c1 = 96'(t.p1z) * 96'(t.p2x) - 96'(t.p1x) * 96'(t.p2z);
        c2 = 96'(t.p1x) * 96'(t.p2y) - 96'(t.p1y) * 96'(t.p2x);
        s0 = 96'(t.v1x) - 96'(t.v2x);
        s1 = 96'(t.v1y) - 96'(t.v2y);
        s2 = 96'(t.v1z) - 96'(t.v2z);
        r.dca = '0;
        r.par = 1'b0;
        if (c0 == 0 && c1 == 0 && c2 == 0)
        begin
            r.par = 1'b1;
            return r;
        end
        dot = s0 * c0 + s1 * c1 + s2 * c2;
        nrm = c0 * c0 + c1 * c1 + c2 * c2;
        det = (dot < 0) ? 200'(-dot) : 200'(dot);
        norm = 200'(nrm);
        rhs = det * det * 200'd256;
        // bitwise search for the largest q with q^2 * norm <= rhs
        for (int b = DistW - 1; b >= 0; b--)
        begin
            trial = 200'(r.dca) | (200'd1 << b);
            lhs = trial * trial * norm;
            if (lhs <= rhs)
                r.dca = trial[DistW-1:0];
        end
        return r;
    endfunction

    function automatic track_pair_t random_pair();
        track_pair_t t;
        int k;
        int mode;
        mode = $urandom_range(0, 9);
        t.p1x = $urandom; t.p1y = $urandom; t.p1z = $urandom;
        t.p2x = $urandom; t.p2y = $urandom; t.p2z = $urandom;
        t.v1x = $urandom; t.v1y = $urandom; t.v1z = $urandom;
        t.v2x = $urandom; t.v2y = $urandom; t.v2z = $urandom;
        if (mode < 2)
        begin
            // small momenta and a small first point; the second point stays random
            t.p1x = $signed(20'($urandom_range(0, 63))) - 32;
            t.p1y = $signed(20'($urandom_range(0, 63))) - 32;
            t.p1z = $signed(20'($urandom_range(0, 63))) - 32;
            t.p2x = $signed(20'($urandom_range(0, 63))) - 32;
            t.p2y = $signed(20'($urandom_range(0, 63))) - 32;
            t.p2z = $signed(20'($urandom_range(0, 63))) - 32;
            t.v1x = $signed(24'($urandom_range(0, 2047))) - 1024;
            t.v1y = $signed(24'($urandom_range(0, 2047))) - 1024;
            t.v1z = $signed(24'($urandom_range(0, 2047))) - 1024;
        end
        else if (mode < 4)
        begin
            // parallel or antiparallel tracks: scale the first momentum
            k = $urandom_range(0, 6) - 3;
            t.p1x = $signed(20'($urandom_range(0, 131071))) - 65536;
            t.p1y = $signed(20'($urandom_range(0, 131071))) - 65536;
            t.p1z = $signed(20'($urandom_range(0, 131071))) - 65536;
            t.p2x = t.p1x * k;
            t.p2y = t.p1y * k;
            t.p2z = t.p1z * k;
        end
        else if (mode == 4)
        begin
            // one momentum zero
            if ($urandom_range(0, 1))
                {t.p1x, t.p1y, t.p1z} = '0;
            else
                {t.p2x, t.p2y, t.p2z} = '0;
        end
        else if (mode == 5)
        begin
            // nearly parallel: small cross product, large separations
            t.p2x = t.p1x + $signed(20'($urandom_range(0, 2))) - 1;
            t.p2y = t.p1y;
            t.p2z = t.p1z + $signed(20'($urandom_range(0, 2))) - 1;
        end
        return t;
    endfunction

    function automatic track_pair_t make_pair(int p1x, int p1y, int p1z,
                                              int p2x, int p2y, int p2z,
                                              int v1x, int v1y, int v1z,
                                              int v2x, int v2y, int v2z);
        track_pair_t t;
        t.p1x = p1x; t.p1y = p1y; t.p1z = p1z;
        t.p2x = p2x; t.p2y = p2y; t.p2z = p2z;
        t.v1x = v1x; t.v1y = v1y; t.v1z = v1z;
        t.v2x = v2x; t.v2y = v2y; t.v2z = v2z;
        return t;
    endfunction

    // Driver: advance to the next pending pair once the current one transferred.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            quiet = (pair_queue.size() < QuietTail);
            if (!in_valid || in_took)
            begin
                if (in_gap == 0 && !quiet && $urandom_range(0, 15) == 0)
                    in_gap = $urandom_range(1, 8);
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pair_queue.size() > 0)
                begin
                    track_pair_t t;
                    t = pair_queue.pop_front();
                    first_px <= t.p1x; first_py <= t.p1y; first_pz <= t.p1z;
                    second_px <= t.p2x; second_py <= t.p2y; second_pz <= t.p2z;
                    first_vx <= t.v1x; first_vy <= t.v1y; first_vz <= t.v1z;
                    second_vx <= t.v2x; second_vy <= t.v2y; second_vz <= t.v2z;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            // Stall the output side in bursts, except in the quiet tail.
            if (out_gap == 0 && !quiet && $urandom_range(0, 11) == 0)
                out_gap = $urandom_range(1, 8);
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: predict on each input transfer, check each output transfer.
    always @(posedge clk)
    begin
        in_took <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                track_pair_t t;
                t.p1x = first_px; t.p1y = first_py; t.p1z = first_pz;
                t.p2x = second_px; t.p2y = second_py; t.p2z = second_pz;
                t.v1x = first_vx; t.v1y = first_vy; t.v1z = first_vz;
                t.v2x = second_vx; t.v2y = second_vy; t.v2z = second_vz;
                approach_queue.push_back(closest_approach(t));
            end
            if (out_valid && out_ready)
            begin
                if (approach_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: dist=%0d par=%0b",
                                 closest_distance, parallel_flag);
                end
                else
                begin
                    approach_t e;
                    e = approach_queue.pop_front();
                    if (closest_distance !== e.dca || parallel_flag !== e.par)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: dist exp=%0d got=%0d, par exp=%0b got=%0b",
                                     e.dca, closest_distance, e.par, parallel_flag);
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= StallLimit)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed: extremes of every field, zero and parallel momenta.
        pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pair_queue.push_back(make_pair(1, 0, 0, 0, 1, 0, 0, 0, 5, 0, 0, 0));
        pair_queue.push_back(make_pair(1, 0, 0, 0, 1, 0, 0, 0, -5, 0, 0, 0));
        pair_queue.push_back(make_pair(3, 4, 5, 6, 8, 10, 100, -20, 7, 0, 0, 0));
        pair_queue.push_back(make_pair(3, 4, 5, -3, -4, -5, 1, 2, 3, 4, 5, 6));
        pair_queue.push_back(make_pair(0, 0, 0, 7, -9, 11, 1, 2, 3, 4, 5, 6));
        pair_queue.push_back(make_pair(-524288, -524288, -524288, 524287, -524288, 524287,
                                       8388607, 8388607, 8388607,
                                       -8388608, -8388608, -8388608));
        pair_queue.push_back(make_pair(-524288, 0, 0, 0, -524288, 0,
                                       0, 0, 8388607, 0, 0, -8388608));
        pair_queue.push_back(make_pair(524287, 524287, 524287, 524287, 524287, 524287,
                                       8388607, -8388608, 8388607,
                                       -8388608, 8388607, -8388608));
        pair_queue.push_back(make_pair(524287, 0, 0, 0, 524287, 0,
                                       -8388608, -8388608, -8388608,
                                       8388607, 8388607, 8388607));
        pair_queue.push_back(make_pair(524287, 524287, 0, 524287, 524286, 0,
                                       0, 0, -8388608, 0, 0, 8388607));
        pair_queue.push_back(make_pair(1, 0, 0, 1, 1, 0, 8388607, 8388607, 8388607,
                                       -8388608, -8388608, -8388608));
        pair_queue.push_back(make_pair(-1, -1, -1, 1, -1, 1, -1, -1, -1, -1, -1, -1));
        pair_queue.push_back(make_pair(-524288, -524288, -524288, -524288, -524288,
                                       -524288, 0, 0, 0, 1, 1, 1));
        pair_queue.push_back(make_pair(-524288, 524287, -524288, 524287, -524288, 524287,
                                       5, -5, 5, -5, 5, -5));
        pair_queue.push_back(make_pair(2, -3, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < NumRandom; i++)
            pair_queue.push_back(random_pair());

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for the stimulus to go out and every result to come back.
        while (pair_queue.size() > 0 || in_valid || approach_queue.size() > 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (mismatches == 0 && approach_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### track_closest_approach_distance.f
hw/rtl/tcad_pkg.sv
hw/rtl/tcad_front.sv
hw/rtl/tcad_root_stage.sv
hw/rtl/track_closest_approach_distance.sv
tb/sv/tb_track_closest_approach_distance.sv
